FILE: rtl/core/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg
// Shared constants, default parameters and the exponent table builder for
// the Mish activation pipeline.
// ----------------------------------------------------------------------------
package mau_pkg;

  // Default sample format: signed Q4.11 and a 256-entry exponent table.
  localparam int DEF_DATA_WIDTH       = 16;
  localparam int DEF_FRAC_BITS        = 11;
  localparam int DEF_TABLE_INDEX_BITS = 8;

  // Internal fixed-point precision and derived widths.
  localparam int Q_BITS       = 30;
  localparam int EXP_TERMS    = 24;
  localparam int K_W          = 6;
  localparam int T_W          = Q_BITS + K_W;
  localparam int ROM_W        = Q_BITS + 1;
  localparam int POLY_W       = Q_BITS + 1;
  localparam int M_W          = Q_BITS + 1;
  localparam int MM_W         = 2 * M_W - 2;
  localparam int NUM_W        = MM_W + 2;
  localparam int TOP_EXP      = 2 * Q_BITS - 1;
  localparam int FRONT_STAGES = 9;

  // Range limits in whole units of the input format.
  localparam int HI_LIMIT = 8;
  localparam int LO_LIMIT = 16;

  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;

  // 2^(idx / 2^tib) in Q30, from a truncated Taylor series of e^a with every
  // product truncated to Q30. Only called with constant arguments.
  function automatic logic [ROM_W-1:0] pow2_entry(input int unsigned idx,
                                                  input int unsigned tib);
    logic [63:0] arg;
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned n;
    arg  = (64'(idx) * 64'(LN2_Q30)) >> tib;
    sum  = 64'd1 << Q_BITS;
    term = 64'd1 << Q_BITS;
    for (n = 1; n <= EXP_TERMS; n++) begin
      term = ((term * arg) >> Q_BITS) / 64'(n);
      sum  = sum + term;
    end
    return ROM_W'(sum);
  endfunction

endpackage

FILE: rtl/core/mish_activation_unit_top.sv
// ----------------------------------------------------------------------------
// mish_activation_unit_top
// Throughput: one item per cycle, busy is always low. The pipeline holds a
// 30-stage restoring divider for the tanh(softplus) factor, one quotient bit
// per stage, behind nine stages that form e^x and the divider operands, and
// followed by a multiply stage and a rounding stage.
// Reset clears the valid line and the output strobe only; the receiver cannot
// stall the pipeline.
// ----------------------------------------------------------------------------
module mish_activation_unit_top
  import mau_pkg::*;
#(
  parameter int DATA_WIDTH       = DEF_DATA_WIDTH,
  parameter int FRAC_BITS        = DEF_FRAC_BITS,
  parameter int TABLE_INDEX_BITS = DEF_TABLE_INDEX_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_x,
  output logic                         out_strobe,
  output logic signed [DATA_WIDTH-1:0] out_y
);

  localparam int DW       = DATA_WIDTH;
  localparam int TIB      = TABLE_INDEX_BITS;
  localparam int ROM_SIZE = 1 << TIB;
  localparam int LAT      = FRONT_STAGES + Q_BITS + 2;
  localparam int SIDE     = LAT - 1;
  localparam int D_W      = Q_BITS - TIB;
  localparam int A2_W     = 2 * D_W - Q_BITS;
  localparam int P3_W     = A2_W + D_W;
  localparam int A3_W     = (P3_W - Q_BITS > 0) ? P3_W - Q_BITS : 1;
  localparam int D6_S     = A3_W + 3;
  localparam int CW       = ((DW > FRAC_BITS + 5) ? DW : FRAC_BITS + 5) + 1;
  localparam int PR_W     = DW + Q_BITS + 1;

  localparam logic signed [CW-1:0] HI_C = CW'(HI_LIMIT) << FRAC_BITS;
  localparam logic signed [CW-1:0] LO_C = -(CW'(LO_LIMIT) << FRAC_BITS);
  localparam logic [A3_W:0] D6_M = (A3_W+1)'(((64'd1 << D6_S) / 64'd6) + 64'd1);
  localparam logic [POLY_W-1:0] ONE_POLY = POLY_W'(1) << Q_BITS;
  localparam logic [PR_W-1:0] HALF_RND = PR_W'(1) << (Q_BITS - 1);

  // Exponent table, built at elaboration.
  logic [ROM_W-1:0] pow2_tab [ROM_SIZE];

  for (genvar gi = 0; gi < ROM_SIZE; gi++) begin : g_rom
    localparam logic [ROM_W-1:0] ENTRY = pow2_entry(gi, TIB);
    assign pow2_tab[gi] = ENTRY;
  end

  // Valid line and side pipe carrying the sample and its range flags.
  logic [SIDE-1:0]        vld_r;
  logic                   out_strobe_r;
  logic signed [DW-1:0]   x_pipe_r  [SIDE];
  logic                   hi_pipe_r [SIDE];
  logic                   lo_pipe_r [SIDE];

  // Stage 1
  logic signed [CW-1:0]   x_c;
  logic signed [DW+31:0]  t_prod;
  logic signed [DW+31:0]  t_shift;
  logic signed [T_W-1:0]  t_nxt;
  logic [T_W-1:0]         t_r;

  // Stage 2
  logic [D_W-1:0]         d_val;
  logic [TIB-1:0]         rom_idx;
  logic [D_W+Q_BITS-1:0]  a_prod;
  logic [D_W-1:0]         a_nxt;
  logic [D_W-1:0]         a_s2_r;
  logic [ROM_W-1:0]       rom_s2_r;
  logic signed [K_W-1:0]  k_s2_r;

  // Stage 3
  logic [2*D_W-1:0]       a2_prod;
  logic [A2_W-1:0]        a2_nxt;
  logic [D_W-1:0]         a_s3_r;
  logic [A2_W-1:0]        a2_s3_r;
  logic [ROM_W-1:0]       rom_s3_r;
  logic signed [K_W-1:0]  k_s3_r;

  // Stage 4
  logic [P3_W-1:0]        a3_prod;
  logic [A3_W-1:0]        a3_nxt;
  logic [D_W-1:0]         a_s4_r;
  logic [A2_W-1:0]        a2_s4_r;
  logic [A3_W-1:0]        a3_s4_r;
  logic [ROM_W-1:0]       rom_s4_r;
  logic signed [K_W-1:0]  k_s4_r;

  // Stage 5
  logic [2*A3_W:0]        d6_prod;
  logic [A3_W-1:0]        a3_d6;
  logic [POLY_W-1:0]      poly_nxt;
  logic [POLY_W-1:0]      poly_s5_r;
  logic [ROM_W-1:0]       rom_s5_r;
  logic signed [K_W-1:0]  k_s5_r;

  // Stage 6
  logic [ROM_W+POLY_W-1:0] m_prod;
  logic [M_W-1:0]         m_nxt;
  logic [M_W-1:0]         m_s6_r;
  logic signed [K_W-1:0]  k_s6_r;

  // Stage 7
  logic [2*M_W-1:0]       mm_prod;
  logic [MM_W-1:0]        mm_s7_r;
  logic [M_W-1:0]         m_s7_r;
  logic signed [K_W-1:0]  k_s7_r;

  // Stage 8
  logic                   k_neg;
  logic [K_W-1:0]         k_mag;
  logic [K_W:0]           pw_sh;
  logic [MM_W-1:0]        ta_nxt;
  logic [MM_W-1:0]        tb_nxt;
  logic [MM_W-1:0]        pw_nxt;
  logic [MM_W-1:0]        ta_s8_r;
  logic [MM_W-1:0]        tb_s8_r;
  logic [MM_W-1:0]        pw_s8_r;

  // Stage 9 and the divider stages
  logic [NUM_W-1:0]       num_nxt;
  logic [NUM_W-1:0]       den_nxt;
  logic [NUM_W-1:0]       rem_r  [Q_BITS+1];
  logic [NUM_W-1:0]       dden_r [Q_BITS+1];
  logic [Q_BITS-1:0]      quo_r  [Q_BITS+1];
  logic [NUM_W+1:0]       div_diff    [Q_BITS];
  logic                   div_ge      [Q_BITS];
  logic [NUM_W-1:0]       div_rem_nxt [Q_BITS];

  // Final two stages
  logic signed [PR_W-1:0] prod_nxt;
  logic signed [PR_W-1:0] prod_r;
  logic [PR_W-1:0]        rnd_sum;
  logic signed [DW-1:0]   y_nxt;
  logic signed [DW-1:0]   out_y_r;

  assign busy       = 1'b0;
  assign out_strobe = out_strobe_r;
  assign out_y      = out_y_r;

  // Stage 1: x * log2(e) in Q30, floored.
  assign x_c     = CW'(in_x);
  assign t_prod  = (DW+32)'(in_x) * (DW+32)'($signed(LOG2E_Q30));
  assign t_shift = t_prod >>> FRAC_BITS;
  assign t_nxt   = T_W'(t_shift);

  // Stage 2: table lookup on the top fraction bits, ln2 scaling of the rest.
  assign rom_idx = t_r[Q_BITS-1 -: TIB];
  assign d_val   = t_r[D_W-1:0];
  assign a_prod  = (D_W+Q_BITS)'(d_val) * (D_W+Q_BITS)'(LN2_Q30);
  assign a_nxt   = a_prod[D_W+Q_BITS-1:Q_BITS];

  // Stages 3 to 5: third order polynomial for e^a.
  assign a2_prod  = (2*D_W)'(a_s2_r) * (2*D_W)'(a_s2_r);
  assign a2_nxt   = a2_prod[2*D_W-1:Q_BITS];
  assign a3_prod  = P3_W'(a2_s3_r) * P3_W'(a_s3_r);
  assign a3_nxt   = A3_W'(a3_prod >> Q_BITS);
  assign d6_prod  = (2*A3_W+1)'(a3_s4_r) * (2*A3_W+1)'(D6_M);
  assign a3_d6    = A3_W'(d6_prod >> D6_S);
  assign poly_nxt = ONE_POLY + POLY_W'(a_s4_r) + POLY_W'(a2_s4_r >> 1) + POLY_W'(a3_d6);

  // Stages 6 and 7: mantissa of e^x and its square.
  assign m_prod  = (ROM_W+POLY_W)'(rom_s5_r) * (ROM_W+POLY_W)'(poly_s5_r);
  assign m_nxt   = M_W'(m_prod >> Q_BITS);
  assign mm_prod = (2*M_W)'(m_s6_r) * (2*M_W)'(m_s6_r);

  // Stage 8: align u^2/4 and u/2 to Q60 according to the exponent, and pick
  // the weight of the constant term of the denominator.
  assign k_neg  = k_s7_r[K_W-1];
  assign k_mag  = k_neg ? K_W'(-k_s7_r) : K_W'(k_s7_r);
  assign pw_sh  = k_neg ? (K_W+1)'(TOP_EXP) : (K_W+1)'(TOP_EXP) - {k_mag, 1'b0};
  assign ta_nxt = k_neg ? (mm_s7_r >> {k_mag, 1'b0}) : mm_s7_r;
  assign tb_nxt = {m_s7_r, {(Q_BITS-1){1'b0}}} >> k_mag;
  assign pw_nxt = MM_W'(1) << pw_sh;

  // Stage 9: numerator and denominator of the factor.
  assign num_nxt = NUM_W'(ta_s8_r) + NUM_W'(tb_s8_r);
  assign den_nxt = NUM_W'(ta_s8_r) + NUM_W'(tb_s8_r) + NUM_W'(pw_s8_r);

  // Restoring divider, one quotient bit per stage.
  always_comb begin
    for (int j = 0; j < Q_BITS; j++) begin
      div_diff[j]    = {1'b0, rem_r[j], 1'b0} - {2'b00, dden_r[j]};
      div_ge[j]      = !div_diff[j][NUM_W+1];
      div_rem_nxt[j] = div_ge[j] ? div_diff[j][NUM_W-1:0] : {rem_r[j][NUM_W-2:0], 1'b0};
    end
  end

  // Scale the sample by the factor, then round half up.
  assign prod_nxt = PR_W'(x_pipe_r[SIDE-2]) * PR_W'($signed({1'b0, quo_r[Q_BITS]}));
  assign rnd_sum  = prod_r + HALF_RND;

  always_comb begin
    priority if (hi_pipe_r[SIDE-1]) begin
      y_nxt = x_pipe_r[SIDE-1];
    end else if (lo_pipe_r[SIDE-1]) begin
      y_nxt = '0;
    end else begin
      y_nxt = rnd_sum[Q_BITS +: DW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= {vld_r[SIDE-2:0], start};
      out_strobe_r <= vld_r[SIDE-1];
    end
  end

  always_ff @(posedge clk) begin
    x_pipe_r[0]  <= in_x;
    hi_pipe_r[0] <= (x_c >= HI_C);
    lo_pipe_r[0] <= (x_c <= LO_C);
    for (int i = 1; i < SIDE; i++) begin
      x_pipe_r[i]  <= x_pipe_r[i-1];
      hi_pipe_r[i] <= hi_pipe_r[i-1];
      lo_pipe_r[i] <= lo_pipe_r[i-1];
    end

    t_r <= t_nxt;

    a_s2_r   <= a_nxt;
    rom_s2_r <= pow2_tab[rom_idx];
    k_s2_r   <= t_r[T_W-1:Q_BITS];

    a_s3_r   <= a_s2_r;
    a2_s3_r  <= a2_nxt;
    rom_s3_r <= rom_s2_r;
    k_s3_r   <= k_s2_r;

    a_s4_r   <= a_s3_r;
    a2_s4_r  <= a2_s3_r;
    a3_s4_r  <= a3_nxt;
    rom_s4_r <= rom_s3_r;
    k_s4_r   <= k_s3_r;

    poly_s5_r <= poly_nxt;
    rom_s5_r  <= rom_s4_r;
    k_s5_r    <= k_s4_r;

    m_s6_r <= m_nxt;
    k_s6_r <= k_s5_r;

    mm_s7_r <= mm_prod[2*M_W-1:2];
    m_s7_r  <= m_s6_r;
    k_s7_r  <= k_s6_r;

    ta_s8_r <= ta_nxt;
    tb_s8_r <= tb_nxt;
    pw_s8_r <= pw_nxt;

    rem_r[0]  <= num_nxt;
    dden_r[0] <= den_nxt;
    quo_r[0]  <= '0;
    for (int j = 0; j < Q_BITS; j++) begin
      rem_r[j+1]  <= div_rem_nxt[j];
      dden_r[j+1] <= dden_r[j];
      quo_r[j+1]  <= {quo_r[j][Q_BITS-2:0], div_ge[j]};
    end

    prod_r  <= prod_nxt;
    out_y_r <= y_nxt;
  end

endmodule
